### rtl/tsat_pkg.sv
// shared constants and types for the triangle pair overlap unit
package tsat_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int NUM_VERTS          = 3;
   localparam int NUM_AXES           = 2 * NUM_VERTS;
   localparam int FIELDS_PER_TRI     = 2 * NUM_VERTS;
   localparam int RSP_TDATA_W        = 8;

   typedef struct packed {
      logic proj_en;
      logic sep_en;
   } stage_en_type;

endpackage

### rtl/tsat_axis_test.sv
// projection of both triangles onto one axis and the interval gap check
module tsat_axis_test #(
   parameter int COORD_BITS = tsat_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  tsat_pkg::stage_en_type       stage_en,
   input  logic signed [COORD_BITS:0]   axis_x,
   input  logic signed [COORD_BITS:0]   axis_y,
   input  logic signed [COORD_BITS-1:0] a_x [tsat_pkg::NUM_VERTS],
   input  logic signed [COORD_BITS-1:0] a_y [tsat_pkg::NUM_VERTS],
   input  logic signed [COORD_BITS-1:0] b_x [tsat_pkg::NUM_VERTS],
   input  logic signed [COORD_BITS-1:0] b_y [tsat_pkg::NUM_VERTS],
   output logic                         separated
);
   import tsat_pkg::*;

   localparam int PROJ_W = 2 * COORD_BITS + 2;

   logic signed [PROJ_W-1:0] proj_a_in [NUM_VERTS];
   logic signed [PROJ_W-1:0] proj_b_in [NUM_VERTS];
   logic signed [PROJ_W-1:0] proj_a_ff [NUM_VERTS];
   logic signed [PROJ_W-1:0] proj_b_ff [NUM_VERTS];
   logic                     separated_in;
   logic                     separated_ff;

   // exact dot products, one per vertex
   always_comb begin
      for (int k = 0; k < NUM_VERTS; k++) begin
         proj_a_in[k] = PROJ_W'(axis_x) * PROJ_W'(a_x[k]) +
                        PROJ_W'(axis_y) * PROJ_W'(a_y[k]);
         proj_b_in[k] = PROJ_W'(axis_x) * PROJ_W'(b_x[k]) +
                        PROJ_W'(axis_y) * PROJ_W'(b_y[k]);
      end
   end

   // interval of each triangle, strict gap means separated
   always_comb begin
      logic signed [PROJ_W-1:0] lo_a;
      logic signed [PROJ_W-1:0] hi_a;
      logic signed [PROJ_W-1:0] lo_b;
      logic signed [PROJ_W-1:0] hi_b;
      lo_a = proj_a_ff[0];
      hi_a = proj_a_ff[0];
      lo_b = proj_b_ff[0];
      hi_b = proj_b_ff[0];
      for (int k = 1; k < NUM_VERTS; k++) begin
         if (proj_a_ff[k] < lo_a) lo_a = proj_a_ff[k];
         if (proj_a_ff[k] > hi_a) hi_a = proj_a_ff[k];
         if (proj_b_ff[k] < lo_b) lo_b = proj_b_ff[k];
         if (proj_b_ff[k] > hi_b) hi_b = proj_b_ff[k];
      end
      separated_in = (lo_a > hi_b) || (hi_a < lo_b);
   end

   always_ff @(posedge clock) begin
      if (stage_en.proj_en) begin
         proj_a_ff <= proj_a_in;
         proj_b_ff <= proj_b_in;
      end
      if (stage_en.sep_en) begin
         separated_ff <= separated_in;
      end
   end

   assign separated = separated_ff;

endmodule

### rtl/triangle_triangle_sat_overlap_unit.sv
// 2d triangle pair overlap by separating axis test, streaming top level
// throughput: one transaction per cycle unless stalled, in a five stage pipeline
// (input, edge axes, projections, interval check, response register)
// each stage holds its transaction while the next one is full, so bubbles collapse
// reset clears all stage valid flags; payload registers are not reset
module triangle_triangle_sat_overlap_unit #(
   parameter  int COORD_BITS  = tsat_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_TDATA_W = ((4 * tsat_pkg::FIELDS_PER_TRI * COORD_BITS / 2 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_x0, first_y0, first_x1, first_y1, first_x2, first_y2,
   // second_x0, second_y0, second_x1, second_y1, second_x2, second_y2
   input  logic [REQ_TDATA_W-1:0]           req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // overlap
   output logic [tsat_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tsat_pkg::*;

   logic in_adv;
   logic axis_adv;
   logic proj_adv;
   logic sep_adv;
   logic rsp_adv;

   logic in_valid_ff;
   logic axis_valid_ff;
   logic proj_valid_ff;
   logic sep_valid_ff;
   logic rsp_valid_ff;
   logic in_valid_in;
   logic axis_valid_in;
   logic proj_valid_in;
   logic sep_valid_in;
   logic rsp_valid_in;

   logic signed [COORD_BITS-1:0] in_ax_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_ay_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_bx_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_by_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_ax_in [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_ay_in [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_bx_in [NUM_VERTS];
   logic signed [COORD_BITS-1:0] in_by_in [NUM_VERTS];

   logic signed [COORD_BITS-1:0] ax_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] ay_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] bx_ff [NUM_VERTS];
   logic signed [COORD_BITS-1:0] by_ff [NUM_VERTS];
   logic signed [COORD_BITS:0]   axis_x_ff [NUM_AXES];
   logic signed [COORD_BITS:0]   axis_y_ff [NUM_AXES];
   logic signed [COORD_BITS:0]   axis_x_in [NUM_AXES];
   logic signed [COORD_BITS:0]   axis_y_in [NUM_AXES];

   logic [NUM_AXES-1:0] sep_flags;
   logic                overlap_ff;
   logic                overlap_in;
   stage_en_type        stage_en;

   // stage handshake, each stage loads when empty or draining
   assign rsp_adv  = !rsp_valid_ff || rsp_tready;
   assign sep_adv  = !sep_valid_ff || rsp_adv;
   assign proj_adv = !proj_valid_ff || sep_adv;
   assign axis_adv = !axis_valid_ff || proj_adv;
   assign in_adv   = !in_valid_ff || axis_adv;

   assign req_tready = in_adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, overlap_ff};

   assign stage_en.proj_en = proj_adv;
   assign stage_en.sep_en  = sep_adv;

   always_comb begin
      in_valid_in   = in_adv   ? req_tvalid    : in_valid_ff;
      axis_valid_in = axis_adv ? in_valid_ff   : axis_valid_ff;
      proj_valid_in = proj_adv ? axis_valid_ff : proj_valid_ff;
      sep_valid_in  = sep_adv  ? proj_valid_ff : sep_valid_ff;
      rsp_valid_in  = rsp_adv  ? sep_valid_ff  : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         axis_valid_ff <= 1'b0;
         proj_valid_ff <= 1'b0;
         sep_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         axis_valid_ff <= axis_valid_in;
         proj_valid_ff <= proj_valid_in;
         sep_valid_ff  <= sep_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // unpack the request fields
   always_comb begin
      for (int k = 0; k < NUM_VERTS; k++) begin
         in_ax_in[k] = req_tdata[(2 * k) * COORD_BITS +: COORD_BITS];
         in_ay_in[k] = req_tdata[(2 * k + 1) * COORD_BITS +: COORD_BITS];
         in_bx_in[k] = req_tdata[(FIELDS_PER_TRI + 2 * k) * COORD_BITS +: COORD_BITS];
         in_by_in[k] = req_tdata[(FIELDS_PER_TRI + 2 * k + 1) * COORD_BITS +: COORD_BITS];
      end
   end

   // edge perpendiculars, x axis for a zero-length edge
   always_comb begin
      logic signed [COORD_BITS:0] dx;
      logic signed [COORD_BITS:0] dy;
      int                         n;
      for (int e = 0; e < NUM_VERTS; e++) begin
         n  = (e + 1) % NUM_VERTS;
         dx = (COORD_BITS+1)'(in_ax_ff[n]) - (COORD_BITS+1)'(in_ax_ff[e]);
         dy = (COORD_BITS+1)'(in_ay_ff[n]) - (COORD_BITS+1)'(in_ay_ff[e]);
         if (dx == '0 && dy == '0) begin
            axis_x_in[e] = (COORD_BITS+1)'(1);
            axis_y_in[e] = '0;
         end else begin
            axis_x_in[e] = -dy;
            axis_y_in[e] = dx;
         end
         dx = (COORD_BITS+1)'(in_bx_ff[n]) - (COORD_BITS+1)'(in_bx_ff[e]);
         dy = (COORD_BITS+1)'(in_by_ff[n]) - (COORD_BITS+1)'(in_by_ff[e]);
         if (dx == '0 && dy == '0) begin
            axis_x_in[NUM_VERTS + e] = (COORD_BITS+1)'(1);
            axis_y_in[NUM_VERTS + e] = '0;
         end else begin
            axis_x_in[NUM_VERTS + e] = -dy;
            axis_y_in[NUM_VERTS + e] = dx;
         end
      end
   end

   assign overlap_in = !(|sep_flags);

   always_ff @(posedge clock) begin
      if (in_adv) begin
         in_ax_ff <= in_ax_in;
         in_ay_ff <= in_ay_in;
         in_bx_ff <= in_bx_in;
         in_by_ff <= in_by_in;
      end
      if (axis_adv) begin
         ax_ff     <= in_ax_ff;
         ay_ff     <= in_ay_ff;
         bx_ff     <= in_bx_ff;
         by_ff     <= in_by_ff;
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
      end
      if (rsp_adv) begin
         overlap_ff <= overlap_in;
      end
   end

   for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
      tsat_axis_test #(
         .COORD_BITS (COORD_BITS)
      ) u_axis_test (
         .clock     (clock),
         .stage_en  (stage_en),
         .axis_x    (axis_x_ff[j]),
         .axis_y    (axis_y_ff[j]),
         .a_x       (ax_ff),
         .a_y       (ay_ff),
         .b_x       (bx_ff),
         .b_y       (by_ff),
         .separated (sep_flags[j])
      );
   end

   // a stalled request side means every stage is holding a transaction
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && axis_valid_ff && proj_valid_ff &&
                       sep_valid_ff && rsp_valid_ff))
      else $error("request stalled while a pipeline stage is empty");

   // with the response side open, an accepted request reaches the output
   assert property (@(posedge clock)
      ($past(req_tvalid && req_tready, 5) && $past(rsp_tready, 1) &&
       $past(rsp_tready, 2) && $past(rsp_tready, 3) && $past(rsp_tready, 4) &&
       !reset && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) &&
       !$past(reset, 4) && !$past(reset, 5)) |-> rsp_tvalid)
      else $error("response missing after unstalled pipeline pass");

   for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis_chk
      assert property (@(posedge clock) disable iff (reset)
         axis_valid_ff |-> (axis_x_ff[j] != '0 || axis_y_ff[j] != '0))
         else $error("zero separating axis in flight");
   end

endmodule

### tb/tsat_overlap_checker.sv
// overlap checker: predicts the flag of each accepted triangle pair and compares every response
module tsat_overlap_checker #(
   parameter int COORD_BITS  = tsat_pkg::COORD_BITS_DEFAULT,
   parameter int REQ_TDATA_W = 192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [REQ_TDATA_W-1:0]           req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tsat_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               mismatch_count,
   output int                               flags_outstanding
);

   logic        overlap_flags_q[$];
   logic        want_overlap;
   longint      responses_seen;

   // exact separating axis test over the edge normals of both triangles
   function automatic logic predict_overlap(input logic [REQ_TDATA_W-1:0] pair);
      longint                  vx[6];
      longint                  vy[6];
      logic signed [COORD_BITS-1:0] raw;
      longint                  dx, dy, ax, ay, p;
      longint                  lo_first, hi_first, lo_second, hi_second;
      int                      a, k, base, e, n;
      logic                    separated;
      separated = 1'b0;
      for (k = 0; k < 6; k++) begin
         raw   = pair[(2 * k) * COORD_BITS +: COORD_BITS];
         vx[k] = raw;
         raw   = pair[(2 * k + 1) * COORD_BITS +: COORD_BITS];
         vy[k] = raw;
      end
      for (a = 0; a < 6; a++) begin
         base = (a < 3) ? 0 : 3;
         e    = a % 3;
         n    = (e + 1) % 3;
         dx   = vx[base + n] - vx[base + e];
         dy   = vy[base + n] - vy[base + e];
         // zero-length edge falls back to the x axis
         if (dx == 0 && dy == 0) begin
            ax = 1;
            ay = 0;
         end else begin
            ax = -dy;
            ay = dx;
         end
         for (k = 0; k < 6; k++) begin
            p = ax * vx[k] + ay * vy[k];
            if (k == 0) begin
               lo_first = p;
               hi_first = p;
            end else if (k < 3) begin
               if (p < lo_first) lo_first = p;
               if (p > hi_first) hi_first = p;
            end else if (k == 3) begin
               lo_second = p;
               hi_second = p;
            end else begin
               if (p < lo_second) lo_second = p;
               if (p > hi_second) hi_second = p;
            end
         end
         if (lo_first > hi_second || hi_first < lo_second)
            separated = 1'b1;
      end
      return !separated;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at response %0d: %s", responses_seen, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         overlap_flags_q.delete();
         mismatch_count    = 0;
         flags_outstanding = 0;
         responses_seen    = 0;
      end else begin
         // response side first so a stray response is never matched to a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            if (overlap_flags_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, overlap=%b", rsp_tdata[0]));
            end else begin
               want_overlap = overlap_flags_q.pop_front();
               if (rsp_tdata[0] !== want_overlap)
                  report_mismatch($sformatf("overlap=%b, expected %b",
                                            rsp_tdata[0], want_overlap));
            end
            responses_seen++;
         end
         if (req_tvalid && req_tready)
            overlap_flags_q.push_back(predict_overlap(req_tdata));
         flags_outstanding = overlap_flags_q.size();
      end
   end

endmodule

### tb/tb_triangle_triangle_sat_overlap_unit.sv
// testbench top for the triangle pair overlap unit: stimulus, flow control and verdict
module tb_triangle_triangle_sat_overlap_unit;

   localparam int COORD_BITS   = tsat_pkg::COORD_BITS_DEFAULT;
   localparam int REQ_TDATA_W  = ((4 * tsat_pkg::FIELDS_PER_TRI * COORD_BITS / 2 + 7) / 8) * 8;
   localparam int MIN_C        = -(1 << (COORD_BITS - 1));
   localparam int MAX_C        = (1 << (COORD_BITS - 1)) - 1;
   localparam int RANDOM_PAIRS = 800;
   localparam int LONG_HOLD    = 200;
   localparam int CYCLE_LIMIT  = 300000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [REQ_TDATA_W-1:0]           req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [tsat_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int   mismatch_count;
   int   flags_outstanding;
   int   cycle_count = 0;
   int   coord[12];
   int   pairs_offered;
   logic hold_request;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   triangle_triangle_sat_overlap_unit #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tsat_overlap_checker #(
      .COORD_BITS  (COORD_BITS),
      .REQ_TDATA_W (REQ_TDATA_W)
   ) overlap_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatch_count    (mismatch_count),
      .flags_outstanding (flags_outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL triangle_triangle_sat_overlap_unit");
         $finish;
      end
   end

   // drives the current vertex set and holds it until the transaction is taken
   task automatic offer_pair();
      int j, v;
      for (j = 0; j < 12; j++) begin
         v = coord[j];
         if (v < MIN_C) v = MIN_C;
         if (v > MAX_C) v = MAX_C;
         req_tdata[j * COORD_BITS +: COORD_BITS] = v[COORD_BITS-1:0];
      end
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pairs_offered++;
   endtask

   task automatic offer_triangles(input int x0, y0, x1, y1, x2, y2,
                                  input int u0, v0, u1, v1, u2, v2);
      coord = '{x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2};
      offer_pair();
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid = 1'b0;
      repeat (cycles) begin
         req_tdata = {6{$urandom}};
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (flags_outstanding != 0) @(negedge clock);
   endtask

   task automatic fill_random_pair();
      int kind, r, cx, cy, j, t, offx, offy;
      kind = $urandom_range(0, 9);
      r    = 1 << $urandom_range(2, COORD_BITS - 2);
      cx   = $urandom_range(0, 2 * MAX_C + 1) + MIN_C;
      cy   = $urandom_range(0, 2 * MAX_C + 1) + MIN_C;
      for (j = 0; j < 12; j++) begin
         if (kind < 3)
            coord[j] = $urandom_range(0, 2 * MAX_C + 1) + MIN_C;
         else
            coord[j] = ((j % 2 == 0) ? cx : cy) + $urandom_range(0, 2 * r) - r;
      end
      case (kind)
         6: begin
            // degenerate triangle, repeated vertices
            t = $urandom_range(0, 1) * 6;
            coord[t + 2] = coord[t];
            coord[t + 3] = coord[t + 1];
            if ($urandom_range(0, 1)) begin
               coord[t + 4] = coord[t];
               coord[t + 5] = coord[t + 1];
            end
         end
         7: begin
            // shared vertex or shared edge
            coord[6] = coord[2];
            coord[7] = coord[3];
            if ($urandom_range(0, 1)) begin
               coord[8] = coord[0];
               coord[9] = coord[1];
            end
         end
         8: begin
            for (j = 0; j < 12; j++) begin
               case ($urandom_range(0, 4))
                  0: coord[j] = MIN_C;
                  1: coord[j] = MAX_C;
                  2: coord[j] = 0;
                  3: coord[j] = -1;
                  default: ;
               endcase
            end
         end
         9: begin
            // shifted copy, often just touching or just apart
            offx = $urandom_range(0, 2 * r) - r;
            offy = $urandom_range(0, 2 * r) - r;
            for (j = 0; j < 6; j += 2) begin
               coord[6 + j]     = coord[j] + offx;
               coord[6 + j + 1] = coord[j + 1] + offy;
            end
         end
         default: ;
      endcase
   endtask

   // receiver: changing stall patterns, plus one long hold on request
   initial begin : receiver
      int mode, mode_left;
      bit hold_served;
      rsp_tready  = 1'b0;
      mode        = 0;
      mode_left   = 0;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_served = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 1) == 1);
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = (mode_left % 8 < 4);
         endcase
      end
   end

   initial begin : stimulus
      int burst, gap;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      hold_request  = 1'b0;
      pairs_offered = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes and coincident points
      offer_triangles(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                      MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
      offer_triangles(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                      MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
      offer_triangles(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                      MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
      // points apart only in y: x axis fallback cannot see the gap
      offer_triangles(0, MIN_C, 0, MIN_C, 0, MIN_C, 0, MAX_C, 0, MAX_C, 0, MAX_C);
      // full-range triangles sharing the hypotenuse, then apart
      offer_triangles(MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C,
                      MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C);
      offer_triangles(MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C,
                      MAX_C, MAX_C, 0, MAX_C, MAX_C, 0);
      // touching at a vertex, one lsb apart, shared edge, containment
      offer_triangles(0, 0, 16, 0, 0, 16, 16, 0, 32, 0, 16, 16);
      offer_triangles(0, 0, 16, 0, 0, 16, 17, 0, 33, 0, 17, 16);
      offer_triangles(0, 0, 16, 0, 0, 16, 16, 0, 0, 16, 16, 16);
      offer_triangles(-160, -160, 160, -160, 0, 160, -1, 0, 1, 0, 0, 1);
      // collinear triangles
      offer_triangles(0, 0, 16, 16, 32, 32, 0, 32, 32, 0, 40, 40);
      offer_triangles(0, 0, 16, 16, 32, 32, 40, 0, 60, 0, 60, 20);
      // zero-length edge in a degenerate triangle, then further pairs
      offer_triangles(0, 0, 0, 0, 32, 0, 0, 16, 32, 16, 16, 48);
      offer_triangles(MIN_C, 0, MAX_C, 0, 0, 1, 0, MIN_C, 0, MAX_C, 1, 0);
      offer_triangles(-1, -1, -1, -2, -2, -1, 0, 0, 1, 0, 0, 1);
      offer_triangles(21845, -21846, -21846, 21845, 21845, 21845,
                      -21846, -21846, 0, 0, -1, -1);
      wait_drained();

      // long receiver hold while the sender keeps pushing
      hold_request = 1'b1;
      repeat (40) begin
         fill_random_pair();
         offer_pair();
      end
      wait_drained();

      pairs_offered = 0;
      while (pairs_offered < RANDOM_PAIRS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            fill_random_pair();
            offer_pair();
         end
         if ($urandom_range(0, 15) == 0) begin
            wait_drained();
         end else if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            idle_sender(gap);
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS triangle_triangle_sat_overlap_unit");
      else
         $display("FAIL triangle_triangle_sat_overlap_unit");
      $finish;
   end

endmodule

### filelist.f
rtl/tsat_pkg.sv
rtl/tsat_axis_test.sv
rtl/triangle_triangle_sat_overlap_unit.sv
tb/tsat_overlap_checker.sv
tb/tb_triangle_triangle_sat_overlap_unit.sv
